// ===== rtl/core/wbpp_pkg.sv =====
// ----------------------------------------------------------------------------
// wbpp_pkg
// Shared widths, register indexes and beat types of the weighted boundary
// peak picker.
// ----------------------------------------------------------------------------
`default_nettype none

package wbpp_pkg;

   localparam int STRENGTH_W  = 16;
   localparam int WEIGHT_W    = 16;
   localparam int PRODUCT_W   = STRENGTH_W + WEIGHT_W;
   localparam int SUM_W       = PRODUCT_W + 2;
   localparam int FRAC_SHIFT  = 16;
   localparam int VAL_W       = SUM_W - FRAC_SHIFT;
   localparam int OUT_VAL_W   = 19;
   localparam int POSITION_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int DEFAULT_SPAN      = 4;
   localparam int DEFAULT_MAX_NOTES = 65536;

   localparam logic [WEIGHT_W-1:0] RESET_WEIGHT_IOI   = 16'd8192;
   localparam logic [WEIGHT_W-1:0] RESET_WEIGHT_PITCH = 16'd4096;
   localparam logic [WEIGHT_W-1:0] RESET_WEIGHT_REST  = 16'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WEIGHT_IOI   = 2'd0,
      CSR_WEIGHT_PITCH = 2'd1,
      CSR_WEIGHT_REST  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] ioi;
      logic [WEIGHT_W-1:0] pitch;
      logic [WEIGHT_W-1:0] rest;
   } weights_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [VAL_W-1:0] strength;
   } note_beat_type;

endpackage

`default_nettype wire

// ===== rtl/core/wbpp_weigh.sv =====
// ----------------------------------------------------------------------------
// wbpp_weigh
// Three-stage pipeline that forms the combined strength of one note: input
// register, three parallel multiplies, then the sum scaled down by 2^16.
// ----------------------------------------------------------------------------
`default_nettype none

module wbpp_weigh (
   input  logic                               clock,
   input  logic                               reset,
   input  wbpp_pkg::weights_type              weights,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [wbpp_pkg::STRENGTH_W-1:0]    ioi_strength,
   input  logic [wbpp_pkg::STRENGTH_W-1:0]    pitch_strength,
   input  logic [wbpp_pkg::STRENGTH_W-1:0]    rest_strength,
   input  logic                               last_note,
   output wbpp_pkg::note_beat_type            note_out,
   input  logic                               note_ready
);
   import wbpp_pkg::*;

   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic [STRENGTH_W-1:0] s1_ioi_ff;
   logic [STRENGTH_W-1:0] s1_pitch_ff;
   logic [STRENGTH_W-1:0] s1_rest_ff;

   logic                  s2_valid_ff;
   logic                  s2_last_ff;
   logic [PRODUCT_W-1:0]  s2_ioi_ff;
   logic [PRODUCT_W-1:0]  s2_pitch_ff;
   logic [PRODUCT_W-1:0]  s2_rest_ff;

   logic                  s3_valid_ff;
   logic                  s3_last_ff;
   logic [VAL_W-1:0]      s3_strength_ff;

   logic                  s1_ready;
   logic                  s2_ready;
   logic                  s3_ready;
   logic [SUM_W-1:0]      sum;

   assign s3_ready = !s3_valid_ff || note_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign sum = SUM_W'(s2_ioi_ff) + SUM_W'(s2_pitch_ff) + SUM_W'(s2_rest_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_last_ff  <= last_note;
         s1_ioi_ff   <= ioi_strength;
         s1_pitch_ff <= pitch_strength;
         s1_rest_ff  <= rest_strength;
      end
      if (s2_ready) begin
         s2_last_ff  <= s1_last_ff;
         s2_ioi_ff   <= PRODUCT_W'(s1_ioi_ff) * PRODUCT_W'(weights.ioi);
         s2_pitch_ff <= PRODUCT_W'(s1_pitch_ff) * PRODUCT_W'(weights.pitch);
         s2_rest_ff  <= PRODUCT_W'(s1_rest_ff) * PRODUCT_W'(weights.rest);
      end
      if (s3_ready) begin
         s3_last_ff     <= s2_last_ff;
         s3_strength_ff <= sum[FRAC_SHIFT +: VAL_W];
      end
   end

   assign note_out.valid    = s3_valid_ff;
   assign note_out.last     = s3_last_ff;
   assign note_out.strength = s3_strength_ff;

endmodule

`default_nettype wire

// ===== rtl/core/weighted_boundary_peak_picker.sv =====
// ----------------------------------------------------------------------------
// weighted_boundary_peak_picker
// Weighted boundary strength per note and local-maximum peak picking over a
// window of SPAN notes on each side.
// ----------------------------------------------------------------------------
// Notes arrive on the req_ channel, one beat per note, and results leave on
// the rsp_ channel, one beat per reported position. Weights are written on
// the csr_ port; the user must do so only while the block is idle, which the
// block does not enforce. A note's strength passes the input, product and
// sum registers before it reaches the window; the result for position n
// leaves when note n+SPAN reaches the window, so a result follows its note
// by SPAN notes. Throughput is one note per cycle in the body of a sequence
// unless rsp_stall holds a result. A last note holds the window stage while
// it flushes the pending positions, shifting in empty entries one per cycle
// unless rsp_stall holds a result; the flush gives min(notes, SPAN) result
// beats. The input keeps filling the three-stage weighting pipeline meanwhile
// and stalls only once it is full. When rsp_stall holds a result, the
// result register holds and the stages behind it fill before req_stall rises.
// Reset restores the default weights and clears the window and note count.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_boundary_peak_picker #(
   parameter int SPAN      = wbpp_pkg::DEFAULT_SPAN,
   parameter int MAX_NOTES = wbpp_pkg::DEFAULT_MAX_NOTES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [wbpp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wbpp_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [wbpp_pkg::STRENGTH_W-1:0]    req_ioi_strength,
   input  logic [wbpp_pkg::STRENGTH_W-1:0]    req_pitch_strength,
   input  logic [wbpp_pkg::STRENGTH_W-1:0]    req_rest_strength,
   input  logic                               req_last_note,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [wbpp_pkg::POSITION_W-1:0]    rsp_position,
   output logic [wbpp_pkg::OUT_VAL_W-1:0]     rsp_weighted_strength,
   output logic                               rsp_is_boundary,
   output logic                               rsp_end_of_run
);
   import wbpp_pkg::*;

   localparam int WIN_LEN = 2 * SPAN + 1;
   localparam int NOTE_W  = $clog2(MAX_NOTES);
   localparam int STEP_W  = $clog2(SPAN + 1);

   weights_type        weights_ff;
   note_beat_type      note;
   logic               note_ready;
   logic               in_ready;

   logic [VAL_W-1:0]   window_ff [WIN_LEN];
   logic [VAL_W-1:0]   window_in [WIN_LEN];
   logic [NOTE_W-1:0]  notes_seen_ff;
   logic [NOTE_W-1:0]  flush_cur_ff;
   logic [STEP_W-1:0]  flush_step_ff;
   logic               flushing_ff;

   logic                  rsp_valid_ff;
   logic [POSITION_W-1:0] rsp_position_ff;
   logic [VAL_W-1:0]      rsp_strength_ff;
   logic                  rsp_is_boundary_ff;
   logic                  rsp_end_of_run_ff;

   logic               out_ready;
   logic               take;
   logic               flush_go;
   logic               last_eff;
   logic               final_step;
   logic [NOTE_W-1:0]  cur_now;
   logic [STEP_W-1:0]  step_now;
   logic               emit;
   logic               peak;

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff.ioi   <= RESET_WEIGHT_IOI;
         weights_ff.pitch <= RESET_WEIGHT_PITCH;
         weights_ff.rest  <= RESET_WEIGHT_REST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WEIGHT_IOI:   weights_ff.ioi   <= csr_write_data;
            CSR_WEIGHT_PITCH: weights_ff.pitch <= csr_write_data;
            CSR_WEIGHT_REST:  weights_ff.rest  <= csr_write_data;
            default: ;
         endcase
      end
   end

   wbpp_weigh u_weigh (
      .clock          (clock),
      .reset          (reset),
      .weights        (weights_ff),
      .in_valid       (req_valid),
      .in_ready       (in_ready),
      .ioi_strength   (req_ioi_strength),
      .pitch_strength (req_pitch_strength),
      .rest_strength  (req_rest_strength),
      .last_note      (req_last_note),
      .note_out       (note),
      .note_ready     (note_ready)
   );

   assign req_stall  = !in_ready;
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign note_ready = !flushing_ff && out_ready;
   assign take       = note.valid && note_ready;
   assign flush_go   = flushing_ff && out_ready;
   assign last_eff   = note.last || (notes_seen_ff == NOTE_W'(MAX_NOTES - 1));
   assign final_step = flushing_ff && (flush_step_ff == STEP_W'(SPAN));
   assign cur_now    = flushing_ff ? flush_cur_ff : notes_seen_ff;
   assign step_now   = flushing_ff ? flush_step_ff : '0;
   assign emit       = ((NOTE_W + 1)'(cur_now) + (NOTE_W + 1)'(step_now))
                       >= (NOTE_W + 1)'(SPAN);

   always_comb begin
      window_in[0] = flushing_ff ? '0 : note.strength;
      for (int i = 1; i < WIN_LEN; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   // Entries of absent positions are zero and never beat the center value.
   always_comb begin
      peak = 1'b1;
      for (int k = 1; k <= SPAN; k++) begin
         if (window_in[SPAN+k] > window_in[SPAN] ||
             window_in[SPAN-k] > window_in[SPAN]) begin
            peak = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            window_ff[i] <= '0;
         end
         notes_seen_ff <= '0;
         flushing_ff   <= 1'b0;
         flush_step_ff <= '0;
         flush_cur_ff  <= '0;
      end else if (take) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            window_ff[i] <= window_in[i];
         end
         if (last_eff) begin
            notes_seen_ff <= '0;
            flushing_ff   <= 1'b1;
            flush_step_ff <= STEP_W'(1);
            flush_cur_ff  <= notes_seen_ff;
         end else begin
            notes_seen_ff <= notes_seen_ff + NOTE_W'(1);
         end
      end else if (flush_go) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            window_ff[i] <= final_step ? '0 : window_in[i];
         end
         if (final_step) begin
            flushing_ff <= 1'b0;
         end
         flush_step_ff <= flush_step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= (take || flush_go) && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_position_ff    <= POSITION_W'(cur_now) + POSITION_W'(step_now)
                               - POSITION_W'(SPAN);
         rsp_strength_ff    <= window_in[SPAN];
         rsp_is_boundary_ff <= peak && !final_step;
         rsp_end_of_run_ff  <= final_step;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_position          = rsp_position_ff;
   assign rsp_weighted_strength = OUT_VAL_W'(rsp_strength_ff);
   assign rsp_is_boundary       = rsp_is_boundary_ff;
   assign rsp_end_of_run        = rsp_end_of_run_ff;

   a_final_not_boundary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_of_run_ff |-> !rsp_is_boundary_ff)
      else $error("final result of a run is flagged as a boundary");

   a_flush_step_range: assert property (@(posedge clock) disable iff (reset)
      flushing_ff |-> (flush_step_ff != '0) && (flush_step_ff <= STEP_W'(SPAN)))
      else $error("flush step counter out of range");

   a_flush_ends_clean: assert property (@(posedge clock) disable iff (reset)
      final_step && out_ready |=> !flushing_ff && rsp_valid_ff && rsp_end_of_run_ff)
      else $error("flush did not end with the final result");

   a_no_take_in_flush: assert property (@(posedge clock) disable iff (reset)
      flushing_ff |-> notes_seen_ff == '0)
      else $error("note count advanced during a flush");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      notes_seen_ff <= NOTE_W'(MAX_NOTES - 1))
      else $error("note count passed the sequence limit");

endmodule

`default_nettype wire
